// File: sv/p2c_pkg.sv
// Shared constants for the scan polar-to-cartesian converter: widths, register
// map, reset values and the CORDIC arctangent table.
// Depends on nothing; used by the interfaces and the top level.
package p2c_pkg;

  localparam int RANGE_BITS_DEF = 24;
  localparam int ANGLE_BITS_DEF = 32;
  localparam int INDEX_BITS_DEF = 12;

  // Register map: index i sits at byte address 4*i.
  localparam int APB_ADDR_BITS = 4;
  localparam logic [1:0] REG_START_ANGLE = 2'd0;
  localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] REG_MIN_RANGE   = 2'd2;

  localparam logic [31:0] START_ANGLE_RST = 32'd0;
  localparam logic [31:0] ANGLE_STEP_RST  = 32'd2684355;
  localparam logic [23:0] MIN_RANGE_RST   = 24'd10;

  // CORDIC datapath: Q30 values with guard bits.
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam longint HALF_Q30 = 64'sd536870912;

  // Arctangent of 2^-i as a fraction of a turn times 2^32.
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41721,
    32'd20860,     32'd10430,     32'd5215,      32'd2607,     32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81,       32'd40,
    32'd20,        32'd10,        32'd5,         32'd2,        32'd1
  };

endpackage

// File: sv/p2c_ifs.sv
// Valid/ready channel interfaces for range samples in and planar points out.
// Depends on p2c_pkg for default widths.
interface p2c_sample_if #(
  parameter int RANGE_BITS = p2c_pkg::RANGE_BITS_DEF,
  parameter int INDEX_BITS = p2c_pkg::INDEX_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [RANGE_BITS-1:0] range_value;
  logic                  range_ok;
  logic [INDEX_BITS-1:0] beam_number;

  modport source (output valid, range_value, range_ok, beam_number, input ready);
  modport sink   (input valid, range_value, range_ok, beam_number, output ready);
endinterface

interface p2c_point_if #(
  parameter int RANGE_BITS = p2c_pkg::RANGE_BITS_DEF,
  parameter int INDEX_BITS = p2c_pkg::INDEX_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [RANGE_BITS:0]   point_x;
  logic signed [RANGE_BITS:0]   point_y;
  logic        [INDEX_BITS-1:0] point_beam;

  modport source (output valid, point_x, point_y, point_beam, input ready);
  modport sink   (input valid, point_x, point_y, point_beam, output ready);
endinterface

// File: sv/scan_polar_to_cartesian.sv
// Lidar range sample to planar point converter, fully pipelined.
// Throughput: one word per cycle while the skid stage is empty; the 30 CORDIC
// rotation stages set the depth.
// Synchronous active-low reset clears all valid bits and the skid stage and
// loads the register defaults; payload registers are not reset.
// Depends on p2c_pkg and the channel interfaces in p2c_ifs.sv.
module scan_polar_to_cartesian #(
  parameter int RANGE_BITS = p2c_pkg::RANGE_BITS_DEF,
  parameter int ANGLE_BITS = p2c_pkg::ANGLE_BITS_DEF,
  parameter int INDEX_BITS = p2c_pkg::INDEX_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  p2c_sample_if.sink                         in_chan,
  p2c_point_if.source                        out_chan,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [p2c_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int STEPS = p2c_pkg::CORDIC_STEPS;
  localparam int XW    = p2c_pkg::CORDIC_W;
  // The cosine/sine factor is split into a signed high part and a 16-bit
  // unsigned low part so that each multiplier stays near 25 by 18 bits.
  localparam int HW    = XW - 16;
  localparam int PHW   = RANGE_BITS + 1 + HW;
  localparam int PLW   = RANGE_BITS + 16;
  localparam int SW    = PHW + 17;
  localparam int VW    = SW - 30;
  localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  localparam logic signed [SW-1:0] HALF = SW'(p2c_pkg::HALF_Q30);
  localparam logic signed [VW-1:0] LIM_POS = VW'({RANGE_BITS{1'b1}});
  localparam logic signed [VW-1:0] LIM_NEG = -LIM_POS;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access phase; pready
  // is tied high so no transfer has wait states.
  // ---------------------------------------------------------------------------
  logic [31:0] start_angle_r;
  logic [31:0] angle_step_r;
  logic [23:0] min_range_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= p2c_pkg::START_ANGLE_RST;
      angle_step_r  <= p2c_pkg::ANGLE_STEP_RST;
      min_range_r   <= p2c_pkg::MIN_RANGE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        p2c_pkg::REG_START_ANGLE: start_angle_r <= pwdata;
        p2c_pkg::REG_ANGLE_STEP:  angle_step_r  <= pwdata;
        p2c_pkg::REG_MIN_RANGE:   min_range_r   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      p2c_pkg::REG_START_ANGLE: prdata = start_angle_r;
      p2c_pkg::REG_ANGLE_STEP:  prdata = angle_step_r;
      p2c_pkg::REG_MIN_RANGE:   prdata = {8'd0, min_range_r};
      default:                  prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance. The whole pipe moves together whenever the skid stage
  // is empty. While the output register is held, the skid stage takes the one
  // word that leaves the pipe next; after that the pipe and the input stall
  // until the output register has drained the skid stage.
  // ---------------------------------------------------------------------------
  logic skid_v_r;
  logic adv;

  assign adv           = ~skid_v_r;
  assign in_chan.ready = adv;

  // Stage 1: filter the sample and form beam * step. Dropped samples enter
  // the pipe as bubbles, so no result is ever produced for them.
  logic                       s1_v_r;
  logic                       s1_v_nxt;
  logic [RANGE_BITS-1:0]      s1_rng_r;
  logic [INDEX_BITS-1:0]      s1_beam_r;
  logic [31:0]                s1_prod_r;
  logic [INDEX_BITS+31:0]     prod_full;

  assign prod_full = in_chan.beam_number * angle_step_r;
  assign s1_v_nxt  = in_chan.valid & in_chan.range_ok &
                     (32'(in_chan.range_value) >= 32'(min_range_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rng_r  <= in_chan.range_value;
      s1_beam_r <= in_chan.beam_number;
      s1_prod_r <= prod_full[31:0];
    end
  end

  // Stage 2 (CORDIC index 0): beam angle with wrap, quadrant split and the
  // rotation start vector. Index k holds the vector after k rotations.
  logic                          cv_r    [0:STEPS];
  logic signed [XW-1:0]          cx_r    [0:STEPS];
  logic signed [XW-1:0]          cy_r    [0:STEPS];
  logic signed [XW-1:0]          cz_r    [0:STEPS];
  logic [RANGE_BITS-1:0]         crng_r  [0:STEPS];
  logic [INDEX_BITS-1:0]         cbeam_r [0:STEPS];
  logic [1:0]                    cquad_r [0:STEPS];
  logic [31:0]                   angle_nxt;

  assign angle_nxt = (start_angle_r + s1_prod_r) & ANGLE_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (adv) begin
      cv_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0]    <= p2c_pkg::GAIN_Q30;
      cy_r[0]    <= '0;
      cz_r[0]    <= XW'(angle_nxt[29:0]);
      crng_r[0]  <= s1_rng_r;
      cbeam_r[0] <= s1_beam_r;
      cquad_r[0] <= angle_nxt[31:30];
    end
  end

  // One CORDIC rotation per stage: shift-and-add on x and y, the angle
  // residue steers the direction.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic                 dir_pos;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] atan_i;

    assign dir_pos = ~cz_r[i][XW-1];
    assign xs      = cx_r[i] >>> i;
    assign ys      = cy_r[i] >>> i;
    assign atan_i  = XW'(p2c_pkg::ATAN_TURNS[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (adv) begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (dir_pos) begin
          cx_r[i+1] <= cx_r[i] - ys;
          cy_r[i+1] <= cy_r[i] + xs;
          cz_r[i+1] <= cz_r[i] - atan_i;
        end else begin
          cx_r[i+1] <= cx_r[i] + ys;
          cy_r[i+1] <= cy_r[i] - xs;
          cz_r[i+1] <= cz_r[i] + atan_i;
        end
        crng_r[i+1]  <= crng_r[i];
        cbeam_r[i+1] <= cbeam_r[i];
        cquad_r[i+1] <= cquad_r[i];
      end
    end
  end

  // Quadrant stage: map the first-quadrant cosine and sine to the full turn.
  logic                  r_v_r;
  logic signed [XW-1:0]  r_x_r;
  logic signed [XW-1:0]  r_y_r;
  logic signed [XW-1:0]  r_x_nxt;
  logic signed [XW-1:0]  r_y_nxt;
  logic [RANGE_BITS-1:0] r_rng_r;
  logic [INDEX_BITS-1:0] r_beam_r;

  always_comb begin
    case (cquad_r[STEPS])
      2'd1: begin
        r_x_nxt = -cy_r[STEPS];
        r_y_nxt = cx_r[STEPS];
      end
      2'd2: begin
        r_x_nxt = -cx_r[STEPS];
        r_y_nxt = -cy_r[STEPS];
      end
      2'd3: begin
        r_x_nxt = cy_r[STEPS];
        r_y_nxt = -cx_r[STEPS];
      end
      default: begin
        r_x_nxt = cx_r[STEPS];
        r_y_nxt = cy_r[STEPS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (adv) begin
      r_v_r <= cv_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_x_r    <= r_x_nxt;
      r_y_r    <= r_y_nxt;
      r_rng_r  <= crng_r[STEPS];
      r_beam_r <= cbeam_r[STEPS];
    end
  end

  // Multiply stage 1: partial products of range with each factor half.
  logic                   m1_v_r;
  logic signed [PHW-1:0]  m1_xh_r;
  logic signed [PHW-1:0]  m1_yh_r;
  logic [PLW-1:0]         m1_xl_r;
  logic [PLW-1:0]         m1_yl_r;
  logic [INDEX_BITS-1:0]  m1_beam_r;
  logic signed [RANGE_BITS:0] rng_s;

  assign rng_s = $signed({1'b0, r_rng_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (adv) begin
      m1_v_r <= r_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_xh_r   <= rng_s * $signed(r_x_r[XW-1:16]);
      m1_yh_r   <= rng_s * $signed(r_y_r[XW-1:16]);
      m1_xl_r   <= r_rng_r * r_x_r[15:0];
      m1_yl_r   <= r_rng_r * r_y_r[15:0];
      m1_beam_r <= r_beam_r;
    end
  end

  // Multiply stage 2: recombine the halves and add the rounding constant.
  logic                  m2_v_r;
  logic signed [SW-1:0]  m2_xs_r;
  logic signed [SW-1:0]  m2_ys_r;
  logic [INDEX_BITS-1:0] m2_beam_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (adv) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_xs_r   <= (SW'(m1_xh_r) <<< 16) + $signed(SW'(m1_xl_r)) + HALF;
      m2_ys_r   <= (SW'(m1_yh_r) <<< 16) + $signed(SW'(m1_yl_r)) + HALF;
      m2_beam_r <= m1_beam_r;
    end
  end

  // Drop the Q30 fraction (floor) and clamp to the symmetric output range.
  function automatic logic signed [RANGE_BITS:0] sat_coord(
    input logic signed [SW-1:0] s
  );
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] c;
    v = s[SW-1:30];
    if (v > LIM_POS) begin
      c = LIM_POS;
    end else if (v < LIM_NEG) begin
      c = LIM_NEG;
    end else begin
      c = v;
    end
    return c[RANGE_BITS:0];
  endfunction

  logic signed [RANGE_BITS:0] fin_x;
  logic signed [RANGE_BITS:0] fin_y;

  assign fin_x = sat_coord(m2_xs_r);
  assign fin_y = sat_coord(m2_ys_r);

  // ---------------------------------------------------------------------------
  // Output register and skid stage. A word leaving the pipe while the output
  // register is held parks in the skid stage, which then stalls the pipe
  // until the output register drains it.
  // ---------------------------------------------------------------------------
  logic                       out_v_r;
  logic signed [RANGE_BITS:0] out_x_r;
  logic signed [RANGE_BITS:0] out_y_r;
  logic [INDEX_BITS-1:0]      out_beam_r;
  logic signed [RANGE_BITS:0] skid_x_r;
  logic signed [RANGE_BITS:0] skid_y_r;
  logic [INDEX_BITS-1:0]      skid_beam_r;
  logic                       out_take;

  assign out_take = ~out_v_r | out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_take) begin
      out_v_r  <= skid_v_r | m2_v_r;
      skid_v_r <= 1'b0;
    end else if (adv && m2_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      if (skid_v_r) begin
        out_x_r    <= skid_x_r;
        out_y_r    <= skid_y_r;
        out_beam_r <= skid_beam_r;
      end else begin
        out_x_r    <= fin_x;
        out_y_r    <= fin_y;
        out_beam_r <= m2_beam_r;
      end
    end else if (adv) begin
      skid_x_r    <= fin_x;
      skid_y_r    <= fin_y;
      skid_beam_r <= m2_beam_r;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.point_x    = out_x_r;
  assign out_chan.point_y    = out_y_r;
  assign out_chan.point_beam = out_beam_r;

  // The skid stage only ever holds a word behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid stage holds a word while the output register is empty");

  // Saturation is symmetric, so the most negative code never appears.
  a_sat_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_x_r != {1'b1, {RANGE_BITS{1'b0}}}))
    else $error("point_x escaped the saturation limits");

  a_sat_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_y_r != {1'b1, {RANGE_BITS{1'b0}}}))
    else $error("point_y escaped the saturation limits");

  // While the pipe is stalled the last multiply stage must keep its word.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(m2_v_r) && $stable(m2_xs_r) && $stable(m2_beam_r)))
    else $error("pipeline moved while stalled by the skid stage");

endmodule

// File: dv/scan_polar_to_cartesian_tb.sv
// Self-checking testbench for the scan polar-to-cartesian converter.
// Drives range samples and register writes, predicts each planar point with a
// CORDIC model of its own, and compares every returned word. Needs p2c_pkg,
// p2c_ifs.sv and the top level.
`timescale 1ns / 1ps

module scan_polar_to_cartesian_tb;

  localparam int CLK_HALF_NS   = 6;
  localparam int RESET_CYCLES  = 10;
  // The pipeline is 36 deep; allow a margin for the skid stage.
  localparam int DRAIN_CYCLES  = 48;
  localparam int TIMEOUT_NS    = 500_000 * 2 * CLK_HALF_NS;
  localparam int HOLD_CYCLES   = 400;

  localparam int RNG_W = p2c_pkg::RANGE_BITS_DEF;
  localparam int IDX_W = p2c_pkg::INDEX_BITS_DEF;
  localparam int ADR_W = p2c_pkg::APB_ADDR_BITS;

  // Byte addresses of the registers, four bytes apart.
  localparam logic [ADR_W-1:0] ADDR_START_ANGLE = {p2c_pkg::REG_START_ANGLE, 2'b00};
  localparam logic [ADR_W-1:0] ADDR_ANGLE_STEP  = {p2c_pkg::REG_ANGLE_STEP, 2'b00};
  localparam logic [ADR_W-1:0] ADDR_MIN_RANGE   = {p2c_pkg::REG_MIN_RANGE, 2'b00};
  // First address past the register map; writes there must be ignored.
  localparam logic [ADR_W-1:0] ADDR_UNMAPPED    = 4'd12;

  // Rotation constants: inverse CORDIC gain in Q30 and the arctangent of 2^-i
  // as a fraction of a turn scaled by 2^32.
  localparam int     ROT_STEPS  = 30;
  localparam longint ROT_GAIN   = 64'sd652032874;
  localparam longint ROUND_HALF = 64'sd536870912;
  localparam longint COORD_LIM  = (64'sd1 <<< RNG_W) - 1;
  localparam longint ARCTAN_TURNS [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465,  10679838,  5340245,   2670163,  1335087,
    667544,    333772,    166886,    83443,    41721,
    20860,     10430,     5215,      2607,     1303,
    651,       325,       162,       81,       40,
    20,        10,        5,         2,        1
  };

  typedef enum logic [1:0] {
    QUAD_FIRST, QUAD_SECOND, QUAD_THIRD, QUAD_FOURTH
  } quadrant_e;

  typedef struct packed {
    logic signed [RNG_W:0] x;
    logic signed [RNG_W:0] y;
    logic [IDX_W-1:0]      beam;
  } point_t;

  logic clk;
  logic rst_n;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [ADR_W-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  p2c_sample_if in_if ();
  p2c_point_if  out_if ();

  scan_polar_to_cartesian u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow copy of the register file, updated when a write completes.
  logic [31:0]      start_angle_q;
  logic [31:0]      angle_step_q;
  logic [RNG_W-1:0] min_range_q;

  point_t expected_points[$];

  int  error_count;
  int  samples_sent;
  int  samples_dropped;
  int  points_checked;
  int  settings_used;

  // Knobs for the two idling processes. A nonzero hold request makes the
  // receiver refuse words in one stretch whose length the request sets.
  bit  idle_in_en;
  bit  idle_out_en;
  int  hold_request;

  logic [IDX_W-1:0] beam_cursor;

  always begin
    clk = 1'b1;
    #(CLK_HALF_NS);
    clk = 1'b0;
    #(CLK_HALF_NS);
  end

  // Scales a Q30 direction cosine by the range with round-half-up, then clips
  // to the symmetric range of the output field.
  function automatic logic signed [RNG_W:0] scale_range(logic [RNG_W-1:0] rng,
                                                        longint cosine);
    longint v;
    v = (longint'(rng) * cosine + ROUND_HALF) >>> 30;
    if (v > COORD_LIM)
      v = COORD_LIM;
    if (v < -COORD_LIM)
      v = -COORD_LIM;
    return v[RNG_W:0];
  endfunction

  // Works out the point for a kept sample under the current register values.
  function automatic point_t predict_point(logic [RNG_W-1:0] rng, logic [IDX_W-1:0] beam);
    logic [31:0] angle;
    longint      cx;
    longint      cy;
    longint      cz;
    longint      nx;
    longint      ux;
    longint      uy;
    point_t      pt;
    // The product is taken modulo a full turn, which gives the angle wrap.
    angle = start_angle_q + 32'(beam) * angle_step_q;
    cx = ROT_GAIN;
    cy = 0;
    cz = longint'({2'b00, angle[29:0]});
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (cz >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        cz = cz - ARCTAN_TURNS[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        cz = cz + ARCTAN_TURNS[i];
      end
      cx = nx;
    end
    // The top two angle bits rotate the first-quadrant vector into place.
    case (quadrant_e'(angle[31:30]))
      QUAD_SECOND: begin
        ux = -cy;
        uy = cx;
      end
      QUAD_THIRD: begin
        ux = -cx;
        uy = -cy;
      end
      QUAD_FOURTH: begin
        ux = cy;
        uy = -cx;
      end
      default: begin
        ux = cx;
        uy = cy;
      end
    endcase
    pt.x    = scale_range(rng, ux);
    pt.y    = scale_range(rng, uy);
    pt.beam = beam;
    return pt;
  endfunction

  // Scoreboard. Accepted samples are predicted at the edge where they are
  // taken; accepted points are compared with the oldest prediction. Both
  // channels are sampled at the rising edge, before the design updates.
  always @(posedge clk) begin
    point_t want;
    if (rst_n && in_if.valid && in_if.ready) begin
      if (in_if.range_ok && in_if.range_value >= min_range_q)
        expected_points = {expected_points,
                           predict_point(in_if.range_value, in_if.beam_number)};
      else
        samples_dropped++;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d beam=%0d", $time,
                 out_if.point_x, out_if.point_y, out_if.point_beam);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        if (out_if.point_x !== want.x) begin
          $display("%0t: point_x mismatch expected %0d actual %0d (beam %0d)", $time,
                   want.x, out_if.point_x, want.beam);
          error_count++;
        end
        if (out_if.point_y !== want.y) begin
          $display("%0t: point_y mismatch expected %0d actual %0d (beam %0d)", $time,
                   want.y, out_if.point_y, want.beam);
          error_count++;
        end
        if (out_if.point_beam !== want.beam) begin
          $display("%0t: point_beam mismatch expected %0d actual %0d", $time,
                   want.beam, out_if.point_beam);
          error_count++;
        end
      end
    end
  end

  // Receiver. Ready changes only at the falling edge, once per edge. Random
  // stalls, and one long hold on request so that the pipeline fills and pushes
  // back on the input.
  initial begin
    int n;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (idle_out_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        out_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offers one sample and returns at the edge where it is accepted. Valid is
  // left high so that back-to-back words need no gap.
  task automatic send_sample(logic [RNG_W-1:0] rng, logic ok, logic [IDX_W-1:0] beam);
    int gap;
    @(negedge clk);
    if (idle_in_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.range_value <= rng;
    in_if.range_ok    <= ok;
    in_if.beam_number <= beam;
    do
      @(posedge clk);
    while (!in_if.ready);
    samples_sent++;
  endtask

  // Lowers valid and waits until every point has come back, then lets the
  // pipeline run empty in case dropped samples are still in flight.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_points.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [ADR_W-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    case (addr)
      ADDR_START_ANGLE: start_angle_q = data;
      ADDR_ANGLE_STEP:  angle_step_q  = data;
      ADDR_MIN_RANGE:   min_range_q   = data[RNG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_register(logic [ADR_W-1:0] addr, logic [31:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do
      @(posedge clk);
    while (!pready);
    if (prdata !== want) begin
      $display("%0t: register 0x%0h read mismatch expected 0x%08h actual 0x%08h", $time,
               addr, want, prdata);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_registers();
    read_register(ADDR_START_ANGLE, start_angle_q);
    read_register(ADDR_ANGLE_STEP, angle_step_q);
    read_register(ADDR_MIN_RANGE, 32'(min_range_q));
  endtask

  task automatic load_settings(logic [31:0] start, logic [31:0] step, logic [31:0] min_rng);
    wait_idle();
    write_register(ADDR_START_ANGLE, start);
    write_register(ADDR_ANGLE_STEP, step);
    write_register(ADDR_MIN_RANGE, min_rng);
    settings_used++;
  endtask

  // Random sample: mostly consecutive beams of a scan, some scattered beams,
  // ranges spread over all magnitudes and clustered around the threshold.
  task automatic send_random_sample();
    logic [RNG_W-1:0] rng;
    logic             ok;
    logic [IDX_W-1:0] beam;
    case ($urandom_range(0, 7))
      0:       rng = RNG_W'($urandom);
      1:       rng = min_range_q;
      2:       rng = min_range_q - 1'b1;
      default: rng = RNG_W'($urandom & ((32'd1 << $urandom_range(1, RNG_W)) - 1));
    endcase
    ok = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 9) < 7) begin
      beam = beam_cursor;
      beam_cursor = beam_cursor + 1'b1;
    end else begin
      beam = IDX_W'($urandom);
    end
    send_sample(rng, ok, beam);
  endtask

  // Reset values must read back before anything is written.
  task automatic test_register_defaults();
    start_angle_q = p2c_pkg::START_ANGLE_RST;
    angle_step_q  = p2c_pkg::ANGLE_STEP_RST;
    min_range_q   = p2c_pkg::MIN_RANGE_RST;
    settings_used++;
    check_registers();
  endtask

  // Range extremes and the invalid flag under the reset settings.
  task automatic test_range_limits();
    send_sample('0, 1'b1, '0);
    send_sample(RNG_W'(9), 1'b1, IDX_W'(1));
    send_sample(RNG_W'(10), 1'b1, IDX_W'(2));
    send_sample('1, 1'b1, '1);
    // An invalid return is dropped no matter how long the range.
    send_sample('1, 1'b0, IDX_W'(7));
    send_sample('0, 1'b0, '0);
    send_sample(RNG_W'(1234567), 1'b1, IDX_W'(100));
  endtask

  // Fixed angles at each quadrant boundary, just below a full turn and mid-quadrant, at
  // full range so the clipping of the coordinates is exercised too, and at a range of 1000.
  task automatic test_quadrants();
    logic [31:0] angles [6];
    angles = '{32'h0000_0000, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
               32'hFFFF_FFFF, 32'h2000_0000};
    foreach (angles[k]) begin
      load_settings(angles[k], 32'd0, 32'd10);
      send_sample('1, 1'b1, IDX_W'(k));
      send_sample(RNG_W'(1000), 1'b1, '1);
    end
  endtask

  // Beam angles whose sum runs past a full turn.
  task automatic test_angle_wrap();
    load_settings(32'hFFFF_F000, 32'hFFFF_FFFF, 32'd10);
    send_sample(RNG_W'(500000), 1'b1, '0);
    send_sample(RNG_W'(500000), 1'b1, IDX_W'(1));
    send_sample(RNG_W'(500000), 1'b1, '1);
    load_settings(32'hF000_0000, 32'h0010_0000, 32'd10);
    send_sample(RNG_W'(77777), 1'b1, '1);
  endtask

  // Threshold at both ends, bits past the register width, and a write to an
  // address outside the map.
  task automatic test_threshold_edges();
    load_settings(32'h1234_5678, 32'h0002_0000, 32'd0);
    send_sample('0, 1'b1, IDX_W'(3));
    load_settings(32'h1234_5678, 32'h0002_0000, 32'hFFFF_FFFF);
    check_registers();
    send_sample('1, 1'b1, IDX_W'(4));
    send_sample(RNG_W'(24'hFF_FFFE), 1'b1, IDX_W'(5));
    wait_idle();
    write_register(ADDR_UNMAPPED, 32'hDEAD_BEEF);
    check_registers();
  endtask

  // The receiver refuses words for a long stretch while the sender keeps
  // offering them, so the pipeline fills and stalls the input.
  task automatic test_output_backpressure();
    load_settings(32'd0, p2c_pkg::ANGLE_STEP_RST, p2c_pkg::MIN_RANGE_RST);
    hold_request = HOLD_CYCLES;
    repeat (150) send_random_sample();
  endtask

  // Several register settings, the extremes among them, with a stream of
  // random samples under each.
  task automatic test_random_scans(int phases, int per_phase);
    logic [31:0] start;
    logic [31:0] step;
    logic [31:0] min_rng;
    for (int p = 0; p < phases; p++) begin
      start   = $urandom;
      step    = 32'hFFFF_FFFF / $urandom_range(360, 4096);
      min_rng = $urandom_range(0, 2048);
      case (p % 5)
        0: step = 32'd0;
        1: begin
          start = 32'hFFFF_FFFF;
          step  = 32'hFFFF_FFFF;
        end
        2: min_rng = 32'd0;
        3: step = $urandom;
        default: ;
      endcase
      load_settings(start, step, min_rng);
      check_registers();
      beam_cursor = IDX_W'($urandom);
      repeat (per_phase) send_random_sample();
    end
  endtask

  // The last stretch runs with no idling on either side.
  task automatic test_full_rate();
    wait_idle();
    idle_in_en  = 1'b0;
    idle_out_en = 1'b0;
    repeat (300) send_random_sample();
  endtask

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.range_value = '0;
    in_if.range_ok    = 1'b0;
    in_if.beam_number = '0;
    error_count       = 0;
    samples_sent      = 0;
    samples_dropped   = 0;
    points_checked    = 0;
    settings_used     = 0;
    idle_in_en        = 1'b1;
    idle_out_en       = 1'b1;
    hold_request      = 0;
    beam_cursor       = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_register_defaults();
    test_range_limits();
    test_quadrants();
    test_angle_wrap();
    test_threshold_edges();
    test_output_backpressure();
    test_random_scans(5, 275);
    test_full_rate();
    wait_idle();

    $display("Covered %0d samples (%0d dropped) and %0d checked points", samples_sent,
             samples_dropped, points_checked);
    $display("over %0d register settings, with idling, a long output hold and full rate.",
             settings_used);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d points still expected.", expected_points.size());
    $display("FAILURE");
    $finish;
  end

endmodule
